// ===== design/markdown_lexer_tokenizer_macros.svh =====
// Assertion helpers for the checker file of the lexer.
`ifndef MARKDOWN_LEXER_TOKENIZER_MACROS_SVH
`define MARKDOWN_LEXER_TOKENIZER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define MLT_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== design/mlt_pkg.sv =====
`default_nettype none

package mlt_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;

    // Token type codes.
    localparam logic [2:0] TK_EOF     = 3'd0;
    localparam logic [2:0] TK_HASH    = 3'd1;
    localparam logic [2:0] TK_STAR    = 3'd2;
    localparam logic [2:0] TK_TICK    = 3'd3;
    localparam logic [2:0] TK_FENCE   = 3'd4;
    localparam logic [2:0] TK_NEWLINE = 3'd5;
    localparam logic [2:0] TK_TEXT    = 3'd6;

    // Open run modes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_TEXT  = 2'd1;
    localparam logic [1:0] MODE_TICKS = 2'd2;

    // Control bytes.
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_TICK = 8'h60;
    localparam logic [7:0] CH_NL   = 8'h0A;

    localparam int MAX_TOKENS = 3;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  token_type;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [15:0] line_no;
        logic [15:0] col_no;
    } token_t;

    // All tokens caused by one input beat.
    typedef struct packed {
        logic [1:0]                  count;
        token_t [MAX_TOKENS-1:0]     tok;
    } bundle_t;

    function automatic token_t mk_tok(input logic [2:0] ty, input logic [31:0] off,
                                      input logic [31:0] len, input logic [15:0] line,
                                      input logic [15:0] col);
        token_t t;
        t.token_type   = ty;
        t.start_offset = off;
        t.token_length = len;
        t.line_no      = line;
        t.col_no       = col;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== design/mlt_lexer.sv =====
`default_nettype none

module mlt_lexer
    import mlt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_kind,
    input  wire logic [7:0] in_byte,
    input  wire logic       push_ready,
    output logic            push_valid,
    output bundle_t         push_bundle
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    logic                   in_valid_reg;
    logic                   kind_reg;
    logic [7:0]             byte_reg;

    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [1:0]             mode_reg, mode_next;
    logic [1:0]             tick_reg, tick_next;
    logic [OFFSET_BITS-1:0] run_off_reg, run_off_next;
    logic [LINE_BITS-1:0]   run_line_reg, run_line_next;
    logic [COLUMN_BITS-1:0] run_col_reg, run_col_next;

    logic                   fire;
    logic                   is_ctrl;
    logic [OFFSET_BITS-1:0] off_adv;
    logic [LINE_BITS-1:0]   line_adv;
    logic [COLUMN_BITS-1:0] col_adv;
    logic [OFFSET_BITS-1:0] run_off_inc;
    logic [COLUMN_BITS-1:0] run_col_inc;
    token_t                 flush_tok0;
    token_t                 flush_tok1;
    logic [1:0]             flush_n;
    token_t                 here_tok;
    bundle_t                bund;
    logic [1:0]             n;

    assign fire     = in_valid_reg && push_ready;
    assign in_ready = !in_valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= in_kind;
            byte_reg <= in_byte;
        end
    end

    always_comb
    begin
        is_ctrl = (byte_reg == CH_HASH) || (byte_reg == CH_STAR) ||
                  (byte_reg == CH_TICK) || (byte_reg == CH_NL);
        off_adv = (cur_off_reg == OFF_MAX) ? cur_off_reg : cur_off_reg + 1'b1;
        if (byte_reg == CH_NL)
        begin
            line_adv = (cur_line_reg == LINE_MAX) ? cur_line_reg : cur_line_reg + 1'b1;
            col_adv  = COL_ONE;
        end
        else
        begin
            line_adv = cur_line_reg;
            col_adv  = (cur_col_reg == COL_MAX) ? cur_col_reg : cur_col_reg + 1'b1;
        end
        run_off_inc = (run_off_reg == OFF_MAX) ? run_off_reg : run_off_reg + 1'b1;
        run_col_inc = (run_col_reg == COL_MAX) ? run_col_reg : run_col_reg + 1'b1;

        // Tokens released by closing the open run.
        flush_tok0 = mk_tok(TK_TICK, 32'(run_off_reg), 32'd1, 16'(run_line_reg),
                            16'(run_col_reg));
        flush_tok1 = mk_tok(TK_TICK, 32'(run_off_inc), 32'd1, 16'(run_line_reg),
                            16'(run_col_inc));
        case (mode_reg)
            MODE_TEXT:
            begin
                flush_tok0 = mk_tok(TK_TEXT, 32'(run_off_reg), 32'(cur_off_reg - run_off_reg),
                                    16'(run_line_reg), 16'(run_col_reg));
                flush_n = 2'd1;
            end
            MODE_TICKS:
            begin
                flush_n = (tick_reg >= 2'd2) ? 2'd2 : tick_reg;
            end
            default:
            begin
                flush_n = 2'd0;
            end
        endcase

        here_tok = mk_tok(TK_EOF, 32'(cur_off_reg), 32'd0, 16'(cur_line_reg),
                          16'(cur_col_reg));

        cur_off_next  = cur_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        mode_next     = mode_reg;
        tick_next     = tick_reg;
        run_off_next  = run_off_reg;
        run_line_next = run_line_reg;
        run_col_next  = run_col_reg;
        bund          = '0;
        n             = 2'd0;

        if (fire)
        begin
            bund.tok[0] = flush_tok0;
            bund.tok[1] = flush_tok1;
            if (kind_reg)
            begin
                bund.tok[flush_n] = here_tok;
                n             = flush_n + 2'd1;
                cur_off_next  = '0;
                cur_line_next = LINE_ONE;
                cur_col_next  = COL_ONE;
                mode_next     = MODE_NONE;
                tick_next     = 2'd0;
                run_off_next  = '0;
                run_line_next = LINE_ONE;
                run_col_next  = COL_ONE;
            end
            else if (mode_reg == MODE_TICKS && byte_reg == CH_TICK)
            begin
                tick_next = tick_reg + 2'd1;
                if (tick_reg >= 2'd2)
                begin
                    bund.tok[0] = mk_tok(TK_FENCE, 32'(run_off_reg), 32'd3,
                                         16'(run_line_reg), 16'(run_col_reg));
                    n         = 2'd1;
                    mode_next = MODE_NONE;
                    tick_next = 2'd0;
                end
                cur_off_next  = off_adv;
                cur_line_next = line_adv;
                cur_col_next  = col_adv;
            end
            else if (mode_reg == MODE_TEXT && !is_ctrl)
            begin
                cur_off_next  = off_adv;
                cur_line_next = line_adv;
                cur_col_next  = col_adv;
            end
            else
            begin
                n         = flush_n;
                mode_next = MODE_NONE;
                tick_next = 2'd0;
                case (byte_reg)
                    CH_HASH:
                    begin
                        here_tok.token_type = TK_HASH;
                        here_tok.token_length = 32'd1;
                        bund.tok[flush_n] = here_tok;
                        n = flush_n + 2'd1;
                    end
                    CH_STAR:
                    begin
                        here_tok.token_type = TK_STAR;
                        here_tok.token_length = 32'd1;
                        bund.tok[flush_n] = here_tok;
                        n = flush_n + 2'd1;
                    end
                    CH_NL:
                    begin
                        here_tok.token_type = TK_NEWLINE;
                        here_tok.token_length = 32'd1;
                        bund.tok[flush_n] = here_tok;
                        n = flush_n + 2'd1;
                    end
                    CH_TICK:
                    begin
                        mode_next     = MODE_TICKS;
                        tick_next     = 2'd1;
                        run_off_next  = cur_off_reg;
                        run_line_next = cur_line_reg;
                        run_col_next  = cur_col_reg;
                    end
                    default:
                    begin
                        mode_next     = MODE_TEXT;
                        run_off_next  = cur_off_reg;
                        run_line_next = cur_line_reg;
                        run_col_next  = cur_col_reg;
                    end
                endcase
                cur_off_next  = off_adv;
                cur_line_next = line_adv;
                cur_col_next  = col_adv;
            end
        end
        bund.count = n;
    end

    assign push_valid  = fire && (n != 2'd0);
    assign push_bundle = bund;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_off_reg  <= '0;
            cur_line_reg <= LINE_ONE;
            cur_col_reg  <= COL_ONE;
            mode_reg     <= MODE_NONE;
            tick_reg     <= 2'd0;
            run_off_reg  <= '0;
            run_line_reg <= LINE_ONE;
            run_col_reg  <= COL_ONE;
        end
        else
        begin
            cur_off_reg  <= cur_off_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            mode_reg     <= mode_next;
            tick_reg     <= tick_next;
            run_off_reg  <= run_off_next;
            run_line_reg <= run_line_next;
            run_col_reg  <= run_col_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mlt_token_fifo.sv =====
`default_nettype none

module mlt_token_fifo
    import mlt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire bundle_t push_bundle,
    output logic         out_valid,
    input  wire logic    out_ready,
    output token_t       out_tok,
    output logic         out_last
);

    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(FIFO_DEPTH);

    bundle_t             slots_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]          idx_reg, idx_next;
    bundle_t             head;
    logic                push;
    logic                pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign push       = push_valid && push_ready;
    assign head       = slots_reg[rd_ptr_reg];
    assign out_valid  = (cnt_reg != '0);
    assign out_tok    = head.tok[idx_reg];
    assign out_last   = (idx_reg == head.count - 2'd1);
    assign pop        = out_valid && out_ready && out_last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        idx_next    = idx_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_valid && out_ready)
        begin
            idx_next = out_last ? 2'd0 : idx_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

`default_nettype wire

// ===== design/markdown_lexer_tokenizer.sv =====
// Streaming lexer for lightweight markup, one byte per input beat.
// Slave channel: s_tdata carries the byte, s_tuser set marks end of input.
// Master channel: one beat per token. s_tready is high while the token
// queue has room, so the block then takes one byte per cycle.
// A token is offered on m_tvalid once the beat that causes it has passed
// the input register and the lexer logic and been written into the token
// queue, a write that waits while the queue is full. Text runs and
// pending single backticks are released by the byte that ends them.
// One input beat yields up to three tokens; they leave one per cycle and
// m_tlast marks the last token of that beat. The queue holds four beats'
// worth of tokens, which absorbs the multi-token flushes at full byte rate.
// When the receiver stalls, the queue fills and s_tready drops once it is
// full; no token is lost and the master payload holds while m_tready is low.
// Reset (rst_n low, asynchronous) empties the queue and sets the position
// to offset 0, line 1, column 1 with no open run. The end-of-file token
// returns the lexer to that same state for the next document.
// Offset, line and column counters saturate at their maximum values.
`default_nettype none

module markdown_lexer_tokenizer
    import mlt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] kind (1 = end of input)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] start_offset, [63:32] token_length,
                                        // [79:64] line number, [95:80] column number
    output logic [2:0]       m_tuser,   // [2:0] token_type
    output logic             m_tlast    // last token of the beat
);

    logic    push_valid;
    logic    push_ready;
    bundle_t push_bundle;
    token_t  out_tok;

    mlt_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_byte     (s_tdata),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_bundle (push_bundle)
    );

    // Tokens of each beat are queued as a group and sent out one by one.
    mlt_token_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_bundle (push_bundle),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_tok     (out_tok),
        .out_last    (m_tlast)
    );

    assign m_tuser = out_tok.token_type;
    assign m_tdata = {out_tok.col_no, out_tok.line_no,
                      out_tok.token_length, out_tok.start_offset};

endmodule

`default_nettype wire

// ===== design/mlt_checker.sv =====
`default_nettype none
`include "markdown_lexer_tokenizer_macros.svh"

module mlt_checker
    import mlt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    logic        stalled;
    logic [99:0] beat_bits;
    logic [31:0] tok_len;
    logic        eof_seen;
    logic        fence_seen;
    logic        single_seen;

    assign stalled     = m_tvalid && !m_tready;
    assign beat_bits   = {m_tlast, m_tuser, m_tdata};
    assign tok_len     = m_tdata[63:32];
    assign eof_seen    = m_tvalid && (m_tuser == TK_EOF);
    assign fence_seen  = m_tvalid && (m_tuser == TK_FENCE);
    assign single_seen = m_tvalid && ((m_tuser == TK_HASH) || (m_tuser == TK_STAR) ||
                                      (m_tuser == TK_TICK) || (m_tuser == TK_NEWLINE));

    // A stalled token must hold.
    `MLT_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable(beat_bits), "stalled token changed")
    // End of file always closes the group of its beat and has no bytes.
    `MLT_ASSERT(a_eof, !eof_seen || (m_tlast && tok_len == 32'd0), "bad eof token")
    // A fence is the only token of its beat and spans three bytes.
    `MLT_ASSERT(a_fence, !fence_seen || (m_tlast && tok_len == 32'd3), "bad fence token")
    // Single-byte tokens have length one.
    `MLT_ASSERT(a_single, !single_seen || (tok_len == 32'd1), "bad single-byte token length")

endmodule

bind markdown_lexer_tokenizer mlt_checker u_mlt_checker (.*);

`default_nettype wire
